>>> sv/eeb_pkg.sv
`timescale 1ns / 1ps
// Shared types, microcode encoding and control store for the Bezout engine.
package eeb_pkg;

  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] LAST_STEP = PC_W'(5);

  // Step addresses of the microprogram
  localparam logic [PC_W-1:0] STEP_WAIT = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_TEST = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_DINIT = PC_W'(2);
  localparam logic [PC_W-1:0] STEP_DIV = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_UPD = PC_W'(4);
  localparam logic [PC_W-1:0] STEP_EMIT = PC_W'(5);

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_TEST,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_UPDATE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_R1_ZERO,
    COND_CNT_NZ,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic r1_zero;
    logic cnt_nz;
    logic out_busy;
  } status_t;

  // Control store: jump to target when cond holds, else fall through.
  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      STEP_WAIT:  w = '{op: OP_LOAD,     cond: COND_NO_INPUT, target: STEP_WAIT};
      STEP_TEST:  w = '{op: OP_TEST,     cond: COND_R1_ZERO,  target: STEP_EMIT};
      STEP_DINIT: w = '{op: OP_DIV_INIT, cond: COND_NEVER,    target: STEP_WAIT};
      STEP_DIV:   w = '{op: OP_DIV_STEP, cond: COND_CNT_NZ,   target: STEP_DIV};
      STEP_UPD:   w = '{op: OP_UPDATE,   cond: COND_ALWAYS,   target: STEP_TEST};
      STEP_EMIT:  w = '{op: OP_EMIT,     cond: COND_OUT_BUSY, target: STEP_EMIT};
      default:    w = '{op: OP_TEST,     cond: COND_ALWAYS,   target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

>>> sv/eeb_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store lookup and branch logic.
module eeb_seq (
  input  logic                clk,
  input  logic                rst,
  input  eeb_pkg::status_t    status,
  output eeb_pkg::ctrl_word_t ctrl
);
  import eeb_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  assign ctrl = ucode_rom(pc);

  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_INPUT: take = !status.in_valid;
      COND_R1_ZERO:  take = status.r1_zero;
      COND_CNT_NZ:   take = status.cnt_nz;
      COND_OUT_BUSY: take = status.out_busy;
      default:       take = 1'b1;
    endcase
    if (take) begin
      pc_next = ctrl.target;
    end else if (pc == LAST_STEP) begin
      pc_next = STEP_WAIT;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> sv/extended_euclid_bezout.sv
`timescale 1ns / 1ps
// Extended Euclid engine: gcd and Bezout coefficients of two positive operands.
// Each Euclid step is a restoring division, one quotient bit a cycle, with the
// coefficient products accumulated alongside. One item at a time; the next
// beat is taken once the result sits in the output register.
// Reset clears the sequencer and output valid; nothing else needs clearing.
module extended_euclid_bezout #(
  parameter int DATA_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [30:0]        first_value,
  input  logic [30:0]        second_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] coef_larger,
  output logic signed [31:0] coef_smaller,
  output logic [30:0]        gcd_value,
  output logic               operands_swapped
);
  import eeb_pkg::*;

  localparam int OPW   = (DATA_BITS - 1 < 31) ? DATA_BITS - 1 : 31;
  localparam int CNT_W = $clog2(OPW);

  ctrl_word_t ctrl;
  status_t    status;

  logic [OPW-1:0]       r2, r1;
  logic [DATA_BITS-1:0] x2, y2, x1, y1;
  logic [DATA_BITS-1:0] px, py;
  logic [OPW-1:0]       pr, dq;
  logic [CNT_W-1:0]     cnt;
  logic                 swapped;

  logic [OPW-1:0]       a_in, b_in;
  logic                 swap_in;
  logic [OPW:0]         shifted;
  logic [OPW+1:0]       diff;
  logic                 qbit;
  logic                 out_busy;
  logic                 emit_fire;
  logic [63:0]          x_ext, y_ext;

  eeb_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  assign a_in    = first_value[OPW-1:0];
  assign b_in    = second_value[OPW-1:0];
  assign swap_in = a_in < b_in;

  assign in_ready  = ctrl.op == OP_LOAD;
  assign out_busy  = out_valid && !out_ready;
  assign emit_fire = (ctrl.op == OP_EMIT) && !out_busy;

  assign status.in_valid = in_valid;
  assign status.r1_zero  = r1 == '0;
  assign status.cnt_nz   = cnt != '0;
  assign status.out_busy = out_busy;

  // restoring division trial subtract
  assign shifted = {pr, dq[OPW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, r1};
  assign qbit    = !diff[OPW+1];

  assign x_ext = 64'(x2);
  assign y_ext = 64'(y2);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        if (in_valid) begin
          r2      <= swap_in ? b_in : a_in;
          r1      <= swap_in ? a_in : b_in;
          swapped <= swap_in;
          x2      <= DATA_BITS'(1);
          y2      <= '0;
          x1      <= '0;
          y1      <= DATA_BITS'(1);
        end
      end
      OP_TEST: begin
      end
      OP_DIV_INIT: begin
        pr  <= '0;
        dq  <= r2;
        px  <= '0;
        py  <= '0;
        cnt <= CNT_W'(OPW - 1);
      end
      OP_DIV_STEP: begin
        pr  <= qbit ? diff[OPW-1:0] : shifted[OPW-1:0];
        dq  <= {dq[OPW-2:0], qbit};
        // q*x1 and q*y1 built MSB first alongside the quotient
        px  <= (px << 1) + (qbit ? x1 : '0);
        py  <= (py << 1) + (qbit ? y1 : '0);
        cnt <= cnt - CNT_W'(1);
      end
      OP_UPDATE: begin
        x2 <= x1;
        y2 <= y1;
        r2 <= r1;
        x1 <= x2 - px;
        y1 <= y2 - py;
        r1 <= pr;
      end
      OP_EMIT: begin
        if (!out_busy) begin
          coef_larger      <= $signed(x_ext[31:0]);
          coef_smaller     <= $signed(y_ext[31:0]);
          gcd_value        <= 31'(r2);
          operands_swapped <= swapped;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after a beat");

  a_rem_ordered: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_TEST) |-> (r1 <= r2))
    else $error("remainder rows out of order");

  a_partial_rem: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_DIV_STEP) |-> (pr < r1))
    else $error("partial remainder not below divisor");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.op == OP_EMIT))
    else $error("result raised outside emit step");
`endif

endmodule
